// File: hdl/packbits_row_rle_decoder_defines.svh
// Assertion macros shared by the run-length decoder RTL.
// Depends on nothing; users must have signals named clk and rst_n in scope.
`ifndef PACKBITS_ROW_RLE_DECODER_DEFINES_SVH
`define PACKBITS_ROW_RLE_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBRLE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBRLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pbrle_pkg.sv
// Package for the run-length decoder: field widths, decode phase type,
// run constants and configuration register indexes. Depends on nothing.
package pbrle_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned DIM_W   = 16;
    localparam int unsigned BPP_W   = 5;
    localparam int unsigned COL_W   = 18;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] RUN_MARK = 8'h80;
    localparam logic [BYTE_W:0]   RUN_BASE = 9'h101;

    localparam logic [BPP_W-1:0] BPP_PACKED_MONO = 5'd1;
    localparam logic [BPP_W-1:0] BPP_TRUE_COLOR  = 5'd24;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_PIXEL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED     = 2'd3;

    typedef enum logic [1:0] {
        PHASE_CONTROL = 2'd0,
        PHASE_LITERAL = 2'd1,
        PHASE_RUN     = 2'd2
    } phase_t;

endpackage

// File: hdl/packbits_row_rle_decoder.sv
// Top level of the PackBits-style row run-length decoder.
// Depends on pbrle_pkg and packbits_row_rle_decoder_defines.svh.
//
// Usage: pixel-data bytes enter on data_byte with data_valid/data_stall, one
// request per byte. Each decoded packet byte leaves on pixel_byte with its
// repeat_count and the row_end and image_end flags, under pixel_valid and
// pixel_stall. Control bytes yield no request on the output side.
// The configuration registers (width, height, bits per pixel, compressed
// mode) are written through cfg_valid/cfg_ready/cfg_index/cfg_data; the user
// must do so only while the decoder is idle; the block does not enforce this.
// cfg_ready is always high. The byte is captured in an input register, decoded
// against the packet, column and row state, and the result is captured in
// the output register. One byte is taken every cycle as long as the output
// side keeps up; the single decode step between the two registers sets this.
// When pixel_stall is high the output register holds its request and
// data_stall rises as soon as the input register holds a waiting byte.
// Reset clears the registers to width 1, height 1, eight bits per pixel and
// compressed mode, and restarts the decoder at a control byte, column zero,
// row zero. After the last row ends every further byte is taken and dropped.
`include "packbits_row_rle_decoder_defines.svh"

module packbits_row_rle_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pbrle_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pbrle_pkg::DIM_W-1:0]       cfg_data,
    input  logic                              data_valid,
    output logic                              data_stall,
    input  logic [pbrle_pkg::BYTE_W-1:0]      data_byte,
    output logic                              pixel_valid,
    input  logic                              pixel_stall,
    output logic [pbrle_pkg::BYTE_W-1:0]      pixel_byte,
    output logic [pbrle_pkg::BYTE_W-1:0]      repeat_count,
    output logic                              row_end,
    output logic                              image_end
);

    logic [pbrle_pkg::DIM_W-1:0] width_reg;
    logic [pbrle_pkg::DIM_W-1:0] height_reg;
    logic [pbrle_pkg::BPP_W-1:0] bpp_reg;
    logic                        comp_reg;

    logic                         s1_valid_reg;
    logic [pbrle_pkg::BYTE_W-1:0] s1_byte_reg;

    pbrle_pkg::phase_t            phase_reg, phase_next;
    logic [pbrle_pkg::BYTE_W-1:0] lit_reg, lit_next;
    logic [pbrle_pkg::BYTE_W-1:0] run_reg, run_next;
    logic [pbrle_pkg::COL_W-1:0]  col_reg, col_next;
    logic [pbrle_pkg::DIM_W-1:0]  row_reg, row_next;
    logic                         done_reg, done_next;

    logic                         out_valid_reg, out_valid_next;
    logic [pbrle_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [pbrle_pkg::BYTE_W-1:0] out_count_reg, out_count_next;
    logic                         out_rend_reg, out_rend_next;
    logic                         out_iend_reg, out_iend_next;

    logic                         out_free;
    logic                         fire;
    logic                         emit;
    logic                         packet_end;
    logic [pbrle_pkg::BYTE_W-1:0] emit_count;
    logic [pbrle_pkg::BYTE_W-1:0] lit_dec;
    logic [pbrle_pkg::COL_W-1:0]  row_bytes;
    logic [pbrle_pkg::COL_W-1:0]  row_bytes_raw;
    logic [pbrle_pkg::COL_W-1:0]  width_ext;
    logic [pbrle_pkg::COL_W-1:0]  col_sum;
    logic [pbrle_pkg::DIM_W-1:0]  row_inc;
    logic                         rend;
    logic                         iend;

    assign cfg_ready   = 1'b1;
    assign out_free    = !out_valid_reg || !pixel_stall;
    assign fire        = s1_valid_reg && out_free;
    assign data_stall  = s1_valid_reg && !out_free;

    assign pixel_valid  = out_valid_reg;
    assign pixel_byte   = out_byte_reg;
    assign repeat_count = out_count_reg;
    assign row_end      = out_rend_reg;
    assign image_end    = out_iend_reg;

    // Row length in bytes follows from the width and the pixel depth.
    assign width_ext = {{(pbrle_pkg::COL_W - pbrle_pkg::DIM_W){1'b0}}, width_reg};

    always_comb
    begin
        priority if (bpp_reg == pbrle_pkg::BPP_PACKED_MONO)
        begin
            row_bytes_raw = (width_ext + pbrle_pkg::COL_W'(7)) >> 3;
        end
        else if (bpp_reg == pbrle_pkg::BPP_TRUE_COLOR)
        begin
            row_bytes_raw = (width_ext << 1) + width_ext;
        end
        else
        begin
            row_bytes_raw = width_ext;
        end
        row_bytes = (row_bytes_raw == '0) ? pbrle_pkg::COL_W'(1) : row_bytes_raw;
    end

    assign lit_dec = lit_reg - pbrle_pkg::BYTE_W'(1);

    // Packet decoding: decides whether the byte gives a result, its count,
    // and whether it closes a packet.
    always_comb
    begin
        phase_next = phase_reg;
        lit_next   = lit_reg;
        run_next   = run_reg;
        emit       = 1'b0;
        packet_end = 1'b0;
        emit_count = pbrle_pkg::BYTE_W'(1);
        if (fire && !done_reg)
        begin
            if (!comp_reg)
            begin
                emit       = 1'b1;
                packet_end = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    pbrle_pkg::PHASE_LITERAL:
                    begin
                        lit_next   = lit_dec;
                        emit       = 1'b1;
                        packet_end = (lit_dec == '0);
                        if (lit_dec == '0)
                        begin
                            phase_next = pbrle_pkg::PHASE_CONTROL;
                        end
                    end
                    pbrle_pkg::PHASE_RUN:
                    begin
                        phase_next = pbrle_pkg::PHASE_CONTROL;
                        emit       = 1'b1;
                        packet_end = 1'b1;
                        emit_count = run_reg;
                    end
                    default:
                    begin
                        phase_next = pbrle_pkg::PHASE_CONTROL;
                        if (s1_byte_reg > pbrle_pkg::RUN_MARK)
                        begin
                            run_next   = pbrle_pkg::BYTE_W'(pbrle_pkg::RUN_BASE
                                         - {1'b0, s1_byte_reg});
                            phase_next = pbrle_pkg::PHASE_RUN;
                        end
                        else if (s1_byte_reg != '0)
                        begin
                            lit_next   = s1_byte_reg;
                            phase_next = pbrle_pkg::PHASE_LITERAL;
                        end
                    end
                endcase
            end
        end
    end

    // Column and row tracking for the emitted packet byte.
    assign col_sum = col_reg + {{(pbrle_pkg::COL_W - pbrle_pkg::BYTE_W){1'b0}}, emit_count};
    assign row_inc = row_reg + pbrle_pkg::DIM_W'(1);
    assign rend    = emit && packet_end && (col_sum >= row_bytes);
    assign iend    = rend && (row_inc >= height_reg);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        done_next = done_reg;
        if (emit)
        begin
            col_next = rend ? '0 : col_sum;
        end
        if (rend)
        begin
            row_next = row_inc;
        end
        if (iend)
        begin
            done_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_count_next = out_count_reg;
        out_rend_next  = out_rend_reg;
        out_iend_next  = out_iend_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = s1_byte_reg;
            out_count_next = emit_count;
            out_rend_next  = rend;
            out_iend_next  = iend;
        end
        else if (!pixel_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= pbrle_pkg::DIM_W'(1);
            height_reg <= pbrle_pkg::DIM_W'(1);
            bpp_reg    <= pbrle_pkg::BPP_W'(8);
            comp_reg   <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pbrle_pkg::CFG_IMAGE_WIDTH:    width_reg  <= cfg_data;
                pbrle_pkg::CFG_IMAGE_HEIGHT:   height_reg <= cfg_data;
                pbrle_pkg::CFG_BITS_PER_PIXEL: bpp_reg    <= cfg_data[pbrle_pkg::BPP_W-1:0];
                pbrle_pkg::CFG_COMPRESSED:     comp_reg   <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            phase_reg     <= pbrle_pkg::PHASE_CONTROL;
            lit_reg       <= '0;
            run_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!data_stall)
            begin
                s1_valid_reg <= data_valid;
            end
            phase_reg     <= phase_next;
            lit_reg       <= lit_next;
            run_reg       <= run_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_valid && !data_stall)
        begin
            s1_byte_reg <= data_byte;
        end
        out_byte_reg  <= out_byte_next;
        out_count_reg <= out_count_next;
        out_rend_reg  <= out_rend_next;
        out_iend_reg  <= out_iend_next;
    end

    `PBRLE_ASSERT_SAME(a_image_end_has_row_end, out_valid_reg && out_iend_reg,
        out_rend_reg, "Image end flagged without a row end.")
    `PBRLE_ASSERT_NEXT(a_column_clears_on_row_end, rend, col_reg == '0,
        "Column count not cleared after a row end.")
    `PBRLE_ASSERT_NEXT(a_done_is_sticky, done_reg, done_reg,
        "Image done flag cleared without reset.")
    `PBRLE_ASSERT_NEXT(a_no_results_after_done, done_reg && !out_valid_reg,
        !out_valid_reg, "Result produced after the image ended.")
    `PBRLE_ASSERT_SAME(a_literal_has_bytes_left, phase_reg == pbrle_pkg::PHASE_LITERAL,
        lit_reg != '0, "Literal phase with no literal bytes left.")

endmodule
